// ===== design/touch_report_rate_gate_macros.svh =====
// assertion helpers for the rate gate decision module
`ifndef TOUCH_REPORT_RATE_GATE_MACROS_SVH
`define TOUCH_REPORT_RATE_GATE_MACROS_SVH

// checked only out of reset
`define TRRG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define TRRG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/trrg_pkg.sv =====
`timescale 1ns / 1ps

package trrg_pkg;

  localparam int unsigned IdW       = 8;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned NumCoords = 4;
  localparam int unsigned TimeW     = 64;
  localparam int unsigned IntervalW = 32;
  localparam int unsigned ResendW   = 4;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [IntervalW-1:0] MoveIntervalRst = 32'd8000000;
  localparam logic [ResendW-1:0]   HealCountRst    = 4'd2;

  typedef enum logic [1:0] {
    DEC_SKIP  = 2'd0,
    DEC_FRESH = 2'd1,
    DEC_HEAL  = 2'd2
  } decision_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MOVE_INTERVAL = 4'd0,
    REG_HEAL_COUNT    = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [IntervalW-1:0] move_interval;
    logic [ResendW-1:0]   heal_resend_count;
  } cfg_t;

  // coordinate order: finger0 x, finger0 y, finger1 x, finger1 y
  typedef struct packed {
    logic                                f0_active;
    logic                                f1_active;
    logic                                click;
    logic [IdW-1:0]                      f0_id;
    logic [IdW-1:0]                      f1_id;
    logic [NumCoords-1:0][CoordW-1:0]    coords;
    logic [TimeW-1:0]                    now_time;
  } snapshot_t;

endpackage

// ===== design/trrg_cfg.sv =====
`timescale 1ns / 1ps

module trrg_cfg
  import trrg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MOVE_INTERVAL: cfg_d.move_interval     = cfg_wdata_i[IntervalW-1:0];
        REG_HEAL_COUNT:    cfg_d.heal_resend_count = cfg_wdata_i[ResendW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.move_interval     <= MoveIntervalRst;
      cfg_q.heal_resend_count <= HealCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== design/trrg_decide.sv =====
`timescale 1ns / 1ps
`include "touch_report_rate_gate_macros.svh"

module trrg_decide
  import trrg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  snapshot_t snap_i,
  input  cfg_t      cfg_i,
  output decision_e decision_o
);

  snapshot_t        sent_q;
  snapshot_t        sent_d;
  logic [ResendW-1:0] resends_left_q;
  logic [ResendW-1:0] resends_left_d;

  logic             edge_det;
  logic             moved;
  logic [TimeW-1:0] elapsed;
  logic             passed;
  decision_e        decision;

  // sent_q.now_time holds the time of the last send
  assign elapsed  = snap_i.now_time - sent_q.now_time;
  assign passed   = !elapsed[TimeW-1] &&
                    (elapsed >= {{(TimeW-IntervalW){1'b0}}, cfg_i.move_interval});
  assign edge_det = (snap_i.f0_active != sent_q.f0_active) ||
                    (snap_i.f1_active != sent_q.f1_active) ||
                    (snap_i.click     != sent_q.click)     ||
                    (snap_i.f0_id     != sent_q.f0_id)     ||
                    (snap_i.f1_id     != sent_q.f1_id);
  assign moved    = (snap_i.coords != sent_q.coords);

  always_comb begin
    decision       = DEC_SKIP;
    sent_d         = sent_q;
    resends_left_d = resends_left_q;
    priority if (edge_det || moved) begin
      if (edge_det || passed) begin
        decision       = DEC_FRESH;
        sent_d         = snap_i;
        resends_left_d = cfg_i.heal_resend_count;
      end
    end else if ((resends_left_q != '0) && passed) begin
      decision          = DEC_HEAL;
      sent_d.now_time   = snap_i.now_time;
      resends_left_d    = resends_left_q - ResendW'(1);
    end else begin
      decision = DEC_SKIP;
    end
  end

  assign decision_o = decision;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q         <= '0;
      resends_left_q <= '0;
    end else if (fire_i) begin
      sent_q         <= sent_d;
      resends_left_q <= resends_left_d;
    end
  end

  `TRRG_ASSERT(heal_uses_one_resend, fire_i && (decision == DEC_HEAL) |=> resends_left_q == ($past(resends_left_q) - 4'd1), "heal did not use up one resend")
  `TRRG_ASSERT(fresh_refills, fire_i && (decision == DEC_FRESH) |=> (resends_left_q == $past(cfg_i.heal_resend_count)) && (sent_q.now_time == $past(snap_i.now_time)), "fresh send did not refill state")
  `TRRG_ASSERT(skip_keeps_state, fire_i && (decision == DEC_SKIP) |=> $stable(sent_q) && $stable(resends_left_q), "skip changed the sent state")
  `TRRG_ASSERT_ALWAYS(heal_needs_resend, !rst_ni || (decision != DEC_HEAL) || (resends_left_q != '0), "heal with no resend left")

endmodule

// ===== design/touch_report_rate_gate.sv =====
`timescale 1ns / 1ps

// Rate gate for two-finger touchpad snapshots: each accepted word gives one
// decision word (skip, fresh or heal). One word is taken every cycle unless
// the output stalls; the snapshot is registered, judged against the last sent
// snapshot by logic that also updates that snapshot, and the decision is
// registered. Configuration writes are always ready and should only be made
// while no word is in flight.
module touch_report_rate_gate
  import trrg_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     finger0_active_i,
  input  logic                     finger1_active_i,
  input  logic                     click_down_i,
  input  logic [IdW-1:0]           finger0_id_i,
  input  logic [IdW-1:0]           finger1_id_i,
  input  logic signed [CoordW-1:0] finger0_x_i,
  input  logic signed [CoordW-1:0] finger0_y_i,
  input  logic signed [CoordW-1:0] finger1_x_i,
  input  logic signed [CoordW-1:0] finger1_y_i,
  input  logic signed [TimeW-1:0]  now_time_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               decision_o
);

  cfg_t      cfg;
  snapshot_t snap_in;
  snapshot_t snap_q;
  logic      in_valid_q;
  logic      out_valid_q;
  decision_e decision;
  decision_e decision_q;
  logic      advance;
  logic      fire;

  trrg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  always_comb begin
    snap_in.f0_active = finger0_active_i;
    snap_in.f1_active = finger1_active_i;
    snap_in.click     = click_down_i;
    snap_in.f0_id     = finger0_id_i;
    snap_in.f1_id     = finger1_id_i;
    snap_in.coords[0] = finger0_x_i;
    snap_in.coords[1] = finger0_y_i;
    snap_in.coords[2] = finger1_x_i;
    snap_in.coords[3] = finger1_y_i;
    snap_in.now_time  = now_time_i;
  end

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  trrg_decide u_decide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .snap_i     (snap_q),
    .cfg_i      (cfg),
    .decision_o (decision)
  );

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      snap_q <= snap_in;
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      decision_q <= decision;
    end
  end

  assign out_valid_o = out_valid_q;
  assign decision_o  = decision_q;

endmodule

// ===== dv/tb_touch_report_rate_gate.sv =====
`timescale 1ns / 1ps

module tb_touch_report_rate_gate;
  import trrg_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumPhases  = 7;
  localparam int unsigned PhaseItems = 130;
  localparam int unsigned MaxIdle    = 14;
  localparam logic [CfgIdxW-1:0] RegUnmapped = 4'd9;

  logic                     clk_i            = 1'b0;
  logic                     rst_ni           = 1'b0;
  logic                     cfg_valid_i      = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_idx_i        = '0;
  logic [CfgDataW-1:0]      cfg_wdata_i      = '0;
  logic                     in_valid_i       = 1'b0;
  logic                     in_stall_o;
  logic                     finger0_active_i = 1'b0;
  logic                     finger1_active_i = 1'b0;
  logic                     click_down_i     = 1'b0;
  logic [IdW-1:0]           finger0_id_i     = '0;
  logic [IdW-1:0]           finger1_id_i     = '0;
  logic signed [CoordW-1:0] finger0_x_i      = '0;
  logic signed [CoordW-1:0] finger0_y_i      = '0;
  logic signed [CoordW-1:0] finger1_x_i      = '0;
  logic signed [CoordW-1:0] finger1_y_i      = '0;
  logic signed [TimeW-1:0]  now_time_i       = '0;
  logic                     out_valid_o;
  logic                     out_stall_i      = 1'b0;
  logic [1:0]               decision_o;

  touch_report_rate_gate dut (.*);

  // own copy of the gate state and its settings
  cfg_t               gate_cfg   = {MoveIntervalRst, HealCountRst};
  snapshot_t          sent_snap  = '0;
  logic [ResendW-1:0] heals_left = '0;

  decision_e expected_decisions[$];
  snapshot_t pending_snaps[$];
  snapshot_t driven_snap = '0;
  snapshot_t touch_snap  = '0;
  logic [TimeW-1:0] time_cursor = '0;

  bit          idle_on     = 1'b1;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned failures    = 0;
  int unsigned cycle_count = 0;
  int unsigned snaps_sent  = 0;
  int unsigned decision_count[3] = '{default: 0};
  decision_e   due_dec;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic decision_e judge_snapshot(snapshot_t s);
    logic             edge_seen;
    logic             moved;
    logic             due;
    logic [TimeW-1:0] elapsed;
    edge_seen = s.f0_active != sent_snap.f0_active || s.f1_active != sent_snap.f1_active ||
                s.click != sent_snap.click || s.f0_id != sent_snap.f0_id ||
                s.f1_id != sent_snap.f1_id;
    moved     = s.coords != sent_snap.coords;
    elapsed   = s.now_time - sent_snap.now_time;
    due       = !elapsed[TimeW-1] &&
                elapsed >= {{(TimeW-IntervalW){1'b0}}, gate_cfg.move_interval};
    if (edge_seen || moved) begin
      if (edge_seen || due) begin
        sent_snap  = s;
        heals_left = gate_cfg.heal_resend_count;
        return DEC_FRESH;
      end
      return DEC_SKIP;
    end
    if (heals_left != '0 && due) begin
      heals_left         = heals_left - ResendW'(1);
      sent_snap.now_time = s.now_time;
      return DEC_HEAL;
    end
    return DEC_SKIP;
  endfunction

  function automatic int unsigned idle_gap();
    return idle_on ? $urandom_range(0, MaxIdle) : 0;
  endfunction

  function automatic snapshot_t make_snap(logic a0, logic a1, logic click, logic [IdW-1:0] id0,
                                          logic [IdW-1:0] id1, logic [CoordW-1:0] x0,
                                          logic [CoordW-1:0] y0, logic [CoordW-1:0] x1,
                                          logic [CoordW-1:0] y1, logic [TimeW-1:0] t);
    snapshot_t s;
    s.f0_active = a0;
    s.f1_active = a1;
    s.click     = click;
    s.f0_id     = id0;
    s.f1_id     = id1;
    s.coords[0] = x0;
    s.coords[1] = y0;
    s.coords[2] = x1;
    s.coords[3] = y1;
    s.now_time  = t;
    return s;
  endfunction

  function automatic snapshot_t random_snap();
    snapshot_t s;
    s.f0_active = 1'($urandom_range(0, 1));
    s.f1_active = 1'($urandom_range(0, 1));
    s.click     = 1'($urandom_range(0, 1));
    s.f0_id     = IdW'($urandom_range(0, 255));
    s.f1_id     = IdW'($urandom_range(0, 255));
    s.coords    = {$urandom, $urandom};
    s.now_time  = {$urandom, $urandom};
    return s;
  endfunction

  // time steps, mostly clustered around the move interval
  function automatic logic [TimeW-1:0] time_advance();
    logic [TimeW-1:0] span;
    span = {{(TimeW-IntervalW){1'b0}}, gate_cfg.move_interval};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return -TimeW'($urandom_range(1, 1000));
      2, 3, 4: return span + TimeW'($urandom_range(0, 6)) - TimeW'(3);
      5, 6, 7: return {$urandom, $urandom} % (TimeW'(2) * span + TimeW'(1));
      8:       return span - TimeW'(1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic snapshot_t gesture_snap();
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(0, 99);
    time_cursor += time_advance();
    if (pick >= 94) begin
      return random_snap();
    end
    if (pick < 45) begin
      k = $urandom_range(0, NumCoords - 1);
      if ($urandom_range(0, 7) == 0) begin
        touch_snap.coords[k] = CoordW'($urandom);
      end else begin
        touch_snap.coords[k] = touch_snap.coords[k] + CoordW'($urandom_range(0, 32)) - 16'd16;
      end
    end else if (pick >= 70 && pick < 80) begin
      touch_snap.f0_active = ~touch_snap.f0_active;
      touch_snap.f0_id     = IdW'($urandom_range(0, 255));
    end else if (pick >= 80 && pick < 88) begin
      touch_snap.f1_active = ~touch_snap.f1_active;
      touch_snap.f1_id     = IdW'($urandom_range(0, 255));
    end else if (pick >= 88) begin
      touch_snap.click = ~touch_snap.click;
    end
    touch_snap.now_time = time_cursor;
    return touch_snap;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MOVE_INTERVAL: gate_cfg.move_interval = data[IntervalW-1:0];
      REG_HEAL_COUNT:    gate_cfg.heal_resend_count = data[ResendW-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (pending_snaps.size() != 0 || in_valid_i || expected_decisions.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_decisions.push_back(judge_snapshot(driven_snap));
        snaps_sent++;
        gap_left = idle_gap();
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled word
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_snaps.size() > 0) begin
        driven_snap = pending_snaps.pop_front();
        finger0_active_i <= driven_snap.f0_active;
        finger1_active_i <= driven_snap.f1_active;
        click_down_i     <= driven_snap.click;
        finger0_id_i     <= driven_snap.f0_id;
        finger1_id_i     <= driven_snap.f1_id;
        finger0_x_i      <= driven_snap.coords[0];
        finger0_y_i      <= driven_snap.coords[1];
        finger1_x_i      <= driven_snap.coords[2];
        finger1_y_i      <= driven_snap.coords[3];
        now_time_i       <= driven_snap.now_time;
        in_valid_i       <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // decision monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_decisions.size() == 0) begin
          $error("decision: no word expected, got %0d", decision_o);
          failures++;
        end else begin
          due_dec = expected_decisions.pop_front();
          if (decision_o !== due_dec) begin
            $error("decision: expected %0d, got %0d", due_dec, decision_o);
            failures++;
          end
          decision_count[due_dec]++;
        end
        stall_left = idle_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    snapshot_t              s;
    logic [IntervalW-1:0]   iv;
    logic [ResendW-1:0]     hc;
    logic [CfgDataW-1:0]    wdata;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    s = '0;
    pending_snaps.push_back(s);
    s.now_time = 64'h7FFF_FFFF_FFFF_FFFF;
    pending_snaps.push_back(s);
    s = make_snap(1'b1, 1'b0, 1'b0, 8'hFF, 8'h00, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000,
                  64'd100);
    pending_snaps.push_back(s);
    s.now_time = 64'd8000099;
    pending_snaps.push_back(s);
    s.now_time = 64'd8000100;
    pending_snaps.push_back(s);
    s.now_time = 64'd16000100;
    pending_snaps.push_back(s);
    s.now_time = 64'd24000100;
    pending_snaps.push_back(s);
    s.coords[0] = 16'h8000;
    s.coords[1] = 16'h7FFF;
    s.now_time  = 64'd24000099;
    pending_snaps.push_back(s);
    s.now_time = 64'd24000100;
    pending_snaps.push_back(s);
    s.coords[2] = 16'hFFFF;
    s.now_time  = 64'd24000101;
    pending_snaps.push_back(s);
    s.f1_active = 1'b1;
    s.f1_id     = 8'hFF;
    pending_snaps.push_back(s);
    s.click = 1'b1;
    pending_snaps.push_back(s);
    s.f1_id = 8'h00;
    pending_snaps.push_back(s);
    s.f0_id = 8'h00;
    pending_snaps.push_back(s);
    s.f0_active = 1'b0;
    pending_snaps.push_back(s);
    // timestamps wrapping and running backwards
    s.coords[3] = 16'h0001;
    s.now_time  = 64'h8000_0000_0000_0000;
    pending_snaps.push_back(s);
    s.now_time = 64'h7FFF_FFFF_FFFF_FFFF;
    pending_snaps.push_back(s);
    s.now_time = 64'h8000_0000_007A_1200;
    pending_snaps.push_back(s);
    s.coords[3] = 16'h8000;
    s.now_time  = 64'h7FFF_FFFF_FFFF_FFFF;
    pending_snaps.push_back(s);
    s.click = 1'b0;
    pending_snaps.push_back(s);
    s = '0;
    pending_snaps.push_back(s);

    time_cursor = 64'd1_000_000_000;
    for (int p = 1; p <= NumPhases; p++) begin
      settle();
      case (p)
        1: begin
          iv = '0;
          hc = '0;
        end
        2: begin
          iv = '0;
          hc = '1;
        end
        3: begin
          iv = '1;
          hc = '1;
        end
        4: begin
          iv = 32'd1;
          hc = 4'd1;
        end
        5: begin
          iv = IntervalW'($urandom_range(2, 50));
          hc = ResendW'($urandom_range(0, 15));
        end
        6: begin
          iv = $urandom;
          hc = ResendW'($urandom_range(0, 15));
        end
        default: begin
          iv = MoveIntervalRst;
          hc = HealCountRst;
        end
      endcase
      wdata = $urandom;
      if (p == NumPhases) begin
        write_reg(RegUnmapped, wdata);
      end
      write_reg(REG_HEAL_COUNT, {wdata[CfgDataW-1:ResendW], hc});
      write_reg(REG_MOVE_INTERVAL, iv);
      idle_on = (p % 3) != 0;
      for (int i = 0; i < PhaseItems; i++) begin
        pending_snaps.push_back(gesture_snap());
      end
    end
    settle();

    $display("%0d snapshots over %0d gate settings, with and without idle cycles",
             snaps_sent, NumPhases + 1);
    $display("decisions seen: %0d skip, %0d fresh, %0d heal",
             decision_count[DEC_SKIP], decision_count[DEC_FRESH], decision_count[DEC_HEAL]);
    if (failures == 0 && expected_decisions.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
